### hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LCST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define LCST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lcst_pkg.sv
// ============================================================================
// lcst_pkg
// Types, codes and constants shared by the channel select and tint ramp block.
// ============================================================================
package lcst_pkg;

    localparam int NUM_MODES = 8;
    localparam logic [7:0] ARG_MAX = 8'd255;

    // Event kinds carried in s_axis_tuser.
    localparam logic [2:0] K_TRIPLE  = 3'd0;
    localparam logic [2:0] K_FRAME   = 3'd1;
    localparam logic [2:0] K_RELEASE = 3'd2;
    localparam logic [2:0] K_MENU    = 3'd3;

    // Configuration register indexes.
    localparam logic REG_MASK   = 1'b0;
    localparam logic REG_SIMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_HANDLED = 2'd1,
        ST_MENU    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_PUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the accepted event
        logic exec;    // start a search or apply a non-search event
        logic step;    // advance the channel search by one mode
        logic commit;  // finish the channel search
        logic push;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_search;
        logic hit;
    } t_sts;

endpackage

### hw/rtl/led_channel_select_and_tint_ramp.sv
// ============================================================================
// led_channel_select_and_tint_ramp
// Button event handler for channel selection and per-channel tint ramping.
// ============================================================================
// One event is handled at a time. A hold frame, release, menu or other event
// passes through the idle, execute and push states and then the output register
// to m_axis; a triple click adds a channel search of up to NUM_MODES candidates,
// which tests one candidate mode per cycle. A new event is accepted as soon
// as the previous result has been loaded into the output register, even if
// that result has not yet been transferred. Configuration registers sit at
// byte address 0 (enabled_mask) and 4 (simple_mode).
`include "assert_macros.svh"

module led_channel_select_and_tint_ramp #(
    parameter int NUM_MODES = lcst_pkg::NUM_MODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] first_frame, [7:1] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [4:2] channel, [12:5] arg_value, [13] blip_pulse,
    // [14] save_request, [15] refresh_output
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]     r_mask;
    logic           r_simple;
    logic           cfg_wr;
    lcst_pkg::t_cmd cmd;
    lcst_pkg::t_sts sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= 8'hFF;
            r_simple <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == lcst_pkg::REG_MASK) begin
                r_mask <= pwdata[7:0];
            end else begin
                r_simple <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == lcst_pkg::REG_SIMPLE) ? {31'd0, r_simple} : {24'd0, r_mask};

    lcst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lcst_dp #(
        .NUM_MODES (NUM_MODES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_kind   (s_axis_tuser),
        .i_first  (s_axis_tdata[0]),
        .i_mask   (r_mask),
        .i_simple (r_simple),
        .o_data   (m_axis_tdata)
    );

    `LCST_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "event accepted while another is in work")
    `LCST_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "undefined status code")
    `LCST_ASSERT_IMP(a_blip_handled, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[1:0] == lcst_pkg::ST_HANDLED, "blip on an unhandled event")
    `LCST_ASSERT_IMP(a_channel_range, i_clk, i_rst_n, m_axis_tvalid, (NUM_MODES >= 8) || (int'(m_axis_tdata[4:2]) < NUM_MODES), "channel beyond mode count")

endmodule

### hw/rtl/lcst_ctrl.sv
// ============================================================================
// lcst_ctrl
// Sequencer for one event at a time: latch, execute, search if needed, then deliver.
// ============================================================================
module lcst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  lcst_pkg::t_sts i_sts,
    output lcst_pkg::t_cmd o_cmd
);

    lcst_pkg::t_state r_state, n_state;
    logic r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lcst_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        n_ovalid   = r_ovalid && !i_m_tready;
        unique case (r_state)
            lcst_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lcst_pkg::S_EXEC;
                end
            end
            lcst_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.is_search ? lcst_pkg::S_SEARCH : lcst_pkg::S_PUSH;
            end
            lcst_pkg::S_SEARCH: begin
                if (i_sts.hit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lcst_pkg::S_PUSH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            lcst_pkg::S_PUSH: begin
                // Wait here until the output register is free or being emptied.
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.push = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = lcst_pkg::S_IDLE;
                end
            end
            default: n_state = lcst_pkg::S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_ovalid;

endmodule

### hw/rtl/lcst_dp.sv
// ============================================================================
// lcst_dp
// Channel state, per-channel tint values, ramp logic and the output register.
// ============================================================================
module lcst_dp #(
    parameter int NUM_MODES = lcst_pkg::NUM_MODES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lcst_pkg::t_cmd i_cmd,
    output lcst_pkg::t_sts o_sts,
    input  logic [2:0]     i_kind,
    input  logic           i_first,
    input  logic [7:0]     i_mask,
    input  logic           i_simple,
    output logic [15:0]    o_data
);

    localparam int CW   = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int CNTW = $clog2(NUM_MODES + 1);
    localparam logic [CW-1:0]   LAST_MODE = CW'(NUM_MODES - 1);
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(NUM_MODES);

    logic [2:0]      r_kind;
    logic            r_first;
    logic [CW-1:0]   r_cur;
    logic [7:0]      r_args [NUM_MODES];
    logic            r_up;
    logic [7:0]      r_prev;
    logic            r_edge;
    logic            r_owned;
    logic [CW-1:0]   r_next;
    logic [CNTW-1:0] r_count;
    logic [1:0]      r_status;
    logic            r_blip;
    logic            r_save;
    logic            r_refresh;
    logic [15:0]     r_out;

    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] c);
        return (c == LAST_MODE) ? '0 : c + CW'(1);
    endfunction

    // Modes eight and above have no enable bit.
    function automatic logic mode_en(input logic [CW-1:0] c, input logic [7:0] mask);
        logic [4:0] ext;
        ext = 5'(c);
        return (ext < 5'd8) && mask[ext[2:0]];
    endfunction

    logic [7:0] tint;
    logic [7:0] n_tint;
    logic       n_owned, n_edge, n_blip, n_up, n_save, n_refresh;
    logic [1:0] n_status;
    logic       n_write;
    logic [4:0] cur_ext;

    assign tint    = r_args[r_cur];
    assign cur_ext = 5'(r_cur);

    always_comb begin
        n_tint    = tint;
        n_owned   = r_owned;
        n_edge    = r_edge;
        n_blip    = 1'b0;
        n_up      = r_up;
        n_save    = 1'b0;
        n_refresh = 1'b0;
        n_status  = lcst_pkg::ST_NONE;
        n_write   = 1'b0;
        unique case (r_kind)
            lcst_pkg::K_FRAME: begin
                if (r_first) begin
                    n_owned = 1'b1;
                    n_edge  = 1'b0;
                end
                if (n_owned) begin
                    if (r_up && tint < lcst_pkg::ARG_MAX) begin
                        n_tint = tint + 8'd1;
                    end else if (!r_up && tint > 8'd0) begin
                        n_tint = tint - 8'd1;
                    end else if (r_prev == tint) begin
                        n_blip = !n_edge;
                        n_edge = 1'b1;
                    end
                    n_write   = 1'b1;
                    n_status  = lcst_pkg::ST_HANDLED;
                    n_refresh = 1'b1;
                end
            end
            lcst_pkg::K_RELEASE: begin
                n_owned = 1'b0;
                if (tint == 8'd0) begin
                    n_up = 1'b1;
                end else if (tint == lcst_pkg::ARG_MAX) begin
                    n_up = 1'b0;
                end else begin
                    n_up = !r_up;
                end
                n_status  = lcst_pkg::ST_HANDLED;
                n_save    = 1'b1;
                n_refresh = 1'b1;
            end
            lcst_pkg::K_MENU: begin
                n_status = i_simple ? lcst_pkg::ST_NONE : lcst_pkg::ST_MENU;
            end
            default: n_status = lcst_pkg::ST_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_up    <= 1'b1;
            r_prev  <= 8'd0;
            r_edge  <= 1'b0;
            r_owned <= 1'b0;
            for (int i = 0; i < NUM_MODES; i++) begin
                r_args[i] <= 8'd0;
            end
        end else if (i_cmd.exec && r_kind != lcst_pkg::K_TRIPLE) begin
            r_up    <= n_up;
            r_edge  <= n_edge;
            r_owned <= n_owned;
            if (n_write) begin
                r_prev        <= n_tint;
                r_args[r_cur] <= n_tint;
            end
        end else if (i_cmd.commit) begin
            r_cur <= r_next;
        end
    end

    // Event latch, search counters, per-event flags and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_first <= i_first;
        end
        if (i_cmd.exec) begin
            r_next    <= wrap_inc(r_cur);
            r_count   <= CNTW'(1);
            r_status  <= n_status;
            r_blip    <= n_blip;
            r_save    <= n_save;
            r_refresh <= n_refresh;
        end
        if (i_cmd.step) begin
            r_next  <= wrap_inc(r_next);
            r_count <= r_count + CNTW'(1);
        end
        if (i_cmd.commit) begin
            // Landing back on the current mode means no other mode is enabled.
            r_status  <= (r_next != r_cur) ? lcst_pkg::ST_HANDLED : lcst_pkg::ST_NONE;
            r_blip    <= 1'b0;
            r_save    <= (r_next != r_cur);
            r_refresh <= (r_next != r_cur);
        end
        if (i_cmd.push) begin
            r_out <= {r_refresh, r_save, r_blip, tint, cur_ext[2:0], r_status};
        end
    end

    assign o_sts.is_search = (r_kind == lcst_pkg::K_TRIPLE);
    assign o_sts.hit       = mode_en(r_next, i_mask) || (r_count == FULL_CNT);
    assign o_data          = r_out;

endmodule
